FILE: sv/zigzag_varint_codec_assert.svh
// Assertion macros for the zigzag varint codec.
// Included by the top level; relies on clk and arst_n in the including scope.
`ifndef ZIGZAG_VARINT_CODEC_ASSERT_SVH
`define ZIGZAG_VARINT_CODEC_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ZVC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("zigzag_varint_codec: check failed");

// Next-cycle implication, checked outside reset.
`define ZVC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("zigzag_varint_codec: check failed");

`endif

FILE: sv/zvc_pkg.sv
// Shared types, constants and helper functions of the zigzag varint codec.
// No dependencies; used by zigzag_varint_codec.
package zvc_pkg;

	localparam int ValueW   = 64;
	localparam int LenW     = 4;
	localparam int ShiftW   = 6;
	localparam int DigitW   = 7;
	localparam int TdataW   = 80;

	localparam logic [7:0]        ContBit    = 8'h80;
	localparam logic [7:0]        PayMask    = 8'h7f;
	localparam logic [7:0]        HighMask   = 8'h7e;
	localparam logic [ShiftW-1:0] MaxShift   = 6'd63;
	localparam logic [ShiftW-1:0] DigitStep  = 6'd7;

	localparam logic [0:0] CmdDecode = 1'b0;
	localparam logic [0:0] CmdEncode = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DEC  = 4'b0010,
		ST_LEN  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	typedef struct packed {
		logic [7:0]        out_byte;
		logic              byte_valid;
		logic [ValueW-1:0] value_out;
		logic              value_valid;
		logic              error;
		logic [LenW-1:0]   encoded_length;
		logic              last;
	} result_t;

	function automatic logic [ValueW-1:0] zigzag_enc(input logic [ValueW-1:0] v);
		return {v[ValueW-2:0], 1'b0} ^ {ValueW{v[ValueW-1]}};
	endfunction

	function automatic logic [ValueW-1:0] zigzag_dec(input logic [ValueW-1:0] v);
		return {1'b0, v[ValueW-1:1]} ^ {ValueW{v[0]}};
	endfunction

endpackage

FILE: sv/zigzag_varint_codec.sv
// Top level of the zigzag LEB128 varint codec (64-bit values).
// Depends on zvc_pkg and zigzag_varint_codec_assert.svh.
//
//  channel | dir | tdata (low bit up)                                  | tuser (low bit up)
//  s_*     | in  | in_byte[7:0] value_in[71:8] space_left[75:72] pad   | cmd, is_signed
//  m_*     | out | out_byte[7:0] value_out[71:8] encoded_length[75:72] | byte_valid,
//          |     |   pad                                               |   value_valid, error
//  s_tlast carries buffer_end; m_tlast marks the final result of a request.
//
// Steps: a decode request is captured, then makes one pass through the
// accumulate shifter. An encode request is captured and sized to L (1..10, its
// encoded length), then emits one result per cycle while m_tready allows;
// the shared 7-bit right shifter sets both the sizing and the emit loops.
// Reset: arst_n clears the sequencer, the output valid and the decoder state.
// Stalls: s_tready is high only while the sequencer is idle; a result that
// waits on m_tready holds the sequencer in its current step.
module zigzag_varint_codec (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [zvc_pkg::TdataW-1:0] s_tdata,  // in_byte, value_in, space_left, zero pad
	input  logic [1:0]                 s_tuser,  // cmd, is_signed
	input  logic                       s_tlast,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [zvc_pkg::TdataW-1:0] m_tdata,  // out_byte, value_out, encoded_length, pad
	output logic [2:0]                 m_tuser,  // byte_valid, value_valid, error
	output logic                       m_tlast
);

	`include "zigzag_varint_codec_assert.svh"

	// Request fields as unpacked from the slave side.
	logic [7:0]                  in_byte;
	logic [zvc_pkg::ValueW-1:0]  value_in;
	logic [zvc_pkg::LenW-1:0]    space_left;
	logic                        cmd;
	logic                        is_signed;

	assign in_byte    = s_tdata[7:0];
	assign value_in   = s_tdata[71:8];
	assign space_left = s_tdata[75:72];
	assign cmd        = s_tuser[0];
	assign is_signed  = s_tuser[1];

	zvc_pkg::state_t state_q, state_d;

	// Decoder state: survives encode requests untouched.
	logic [zvc_pkg::ValueW-1:0] acc_q, acc_d;
	logic [zvc_pkg::ShiftW-1:0] shift_q, shift_d;

	// Captured request payload.
	logic [7:0]               byte_q;
	logic                     end_q;
	logic                     sign_q;
	logic [zvc_pkg::LenW-1:0] room_q;

	// Encoder working registers.
	logic [zvc_pkg::ValueW-1:0] t_q, t_d;   // sizing copy
	logic [zvc_pkg::ValueW-1:0] v_q, v_d;   // emit copy
	logic [zvc_pkg::LenW-1:0]   len_q, len_d;
	logic [zvc_pkg::LenW-1:0]   idx_q, idx_d;

	// Output register.
	logic              out_valid_q;
	zvc_pkg::result_t  out_q;
	zvc_pkg::result_t  res;
	logic              res_load;
	logic              out_free;

	// Shared unit: one 7-bit right shifter, fed by the sizing copy while
	// sizing and by the emit copy while emitting.
	logic [zvc_pkg::ValueW-1:0] shift_src;
	logic [zvc_pkg::ValueW-1:0] shifted;

	// Decode datapath.
	logic [zvc_pkg::ValueW-1:0] dec_part;
	logic [zvc_pkg::ValueW-1:0] acc_new;
	logic                       dec_ovf;

	assign s_tready = (state_q == zvc_pkg::ST_IDLE);
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		shift_src = (state_q == zvc_pkg::ST_LEN) ? t_q : v_q;
		shifted   = shift_src >> zvc_pkg::DigitW;
	end

	always_comb begin
		dec_part = {{(zvc_pkg::ValueW-8){1'b0}}, byte_q & zvc_pkg::PayMask} << shift_q;
		acc_new  = acc_q | dec_part;
		dec_ovf  = (shift_q == zvc_pkg::MaxShift) && ((byte_q & zvc_pkg::HighMask) != 8'h00);
	end

	// Sequencer.
	always_comb begin
		state_d  = state_q;
		acc_d    = acc_q;
		shift_d  = shift_q;
		t_d      = t_q;
		v_d      = v_q;
		len_d    = len_q;
		idx_d    = idx_q;
		res_load = 1'b0;
		res      = '0;
		case (state_q)
			zvc_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					// Map the value once; both copies start from it.
					t_d   = is_signed ? zvc_pkg::zigzag_enc(value_in) : value_in;
					v_d   = t_d;
					len_d = zvc_pkg::LenW'(1);
					idx_d = '0;
					state_d = (cmd == zvc_pkg::CmdEncode) ? zvc_pkg::ST_LEN
					                                      : zvc_pkg::ST_DEC;
				end
			end
			zvc_pkg::ST_DEC: begin
				if (out_free) begin
					state_d = zvc_pkg::ST_IDLE;
					if (dec_ovf) begin
						// Bits past 63: drop the partial value and flag it.
						res.error = 1'b1;
						res.last  = 1'b1;
						res_load  = 1'b1;
						acc_d     = '0;
						shift_d   = '0;
					end else if ((byte_q & zvc_pkg::ContBit) == 8'h00) begin
						res.value_out   = sign_q ? zvc_pkg::zigzag_dec(acc_new) : acc_new;
						res.value_valid = 1'b1;
						res.last        = 1'b1;
						res_load        = 1'b1;
						acc_d           = '0;
						shift_d         = '0;
					end else if ((shift_q == zvc_pkg::MaxShift) || end_q) begin
						// Too many bytes, or the buffer ends mid-varint.
						res.error = 1'b1;
						res.last  = 1'b1;
						res_load  = 1'b1;
						acc_d     = '0;
						shift_d   = '0;
					end else begin
						// Continuation: advance the shift, no result.
						acc_d   = acc_new;
						shift_d = shift_q + zvc_pkg::DigitStep;
					end
				end
			end
			zvc_pkg::ST_LEN: begin
				if (t_q[zvc_pkg::ValueW-1:zvc_pkg::DigitW] != '0) begin
					t_d   = shifted;
					len_d = len_q + zvc_pkg::LenW'(1);
				end else begin
					state_d = zvc_pkg::ST_EMIT;
				end
			end
			zvc_pkg::ST_EMIT: begin
				if (out_free) begin
					res.encoded_length = len_q;
					res_load           = 1'b1;
					if (idx_q >= room_q) begin
						// Out of room: close with an error after the partial bytes.
						res.error = 1'b1;
						res.last  = 1'b1;
						state_d   = zvc_pkg::ST_IDLE;
					end else begin
						res.out_byte   = (v_q[7:0] & zvc_pkg::PayMask)
						               | ((shifted != '0) ? zvc_pkg::ContBit : 8'h00);
						res.byte_valid = 1'b1;
						res.last       = (idx_q + zvc_pkg::LenW'(1) == len_q);
						v_d            = shifted;
						idx_d          = idx_q + zvc_pkg::LenW'(1);
						if (res.last) begin
							state_d = zvc_pkg::ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = zvc_pkg::ST_IDLE;
			end
		endcase
	end

	// Control and decoder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= zvc_pkg::ST_IDLE;
			acc_q       <= '0;
			shift_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			acc_q   <= acc_d;
			shift_q <= shift_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_q <= in_byte;
			end_q  <= s_tlast;
			sign_q <= is_signed;
			room_q <= space_left;
		end
		t_q   <= t_d;
		v_q   <= v_d;
		len_q <= len_d;
		idx_q <= idx_d;
		if (res_load) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'h0, out_q.encoded_length, out_q.value_out, out_q.out_byte};
	assign m_tuser  = {out_q.error, out_q.value_valid, out_q.byte_valid};
	assign m_tlast  = out_q.last;

	// A request always moves the sequencer out of idle.
	`ZVC_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready)
	// A result is either an encoded byte or a decoded value, never both.
	`ZVC_ASSERT_NOW(a_one_kind, out_valid_q, !(out_q.byte_valid && out_q.value_valid))
	// Encoded bytes carry a length from one to ten.
	`ZVC_ASSERT_NOW(a_len_range, out_valid_q && out_q.byte_valid,
		(out_q.encoded_length != 4'd0) && (out_q.encoded_length <= 4'd10))
	// The emit counter never runs past the encoded length.
	`ZVC_ASSERT_NOW(a_idx_bound, state_q == zvc_pkg::ST_EMIT, idx_q < len_q)

endmodule
